// File: design/pds_pkg.sv
// Package for the PLL divider search: sequencer states and fixed constants.
// No dependencies; imported by pll_divider_search.
`timescale 1ns / 1ps
package pds_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_LOAD, ST_MDIV, ST_MCHK, ST_MUL,
    ST_VCHK, ST_ADIV, ST_ERR, ST_NEXT, ST_FIN
  } pds_state_t;

  localparam int unsigned RefW   = 27;
  localparam int unsigned TgtW   = 19;
  localparam int unsigned HzW    = 29;   // target in Hz
  localparam int unsigned NumW   = 41;   // 2*target*div*n + fref
  localparam int unsigned VcoW   = 35;   // fref*m
  localparam int unsigned ErrW   = 30;

  localparam logic [RefW-1:0] RefReset  = 27'd14318180;
  localparam logic [ErrW-1:0] StartErr  = 30'd1000000000;
  localparam logic [VcoW-1:0] GoodErr   = 35'd1000;
  localparam logic [VcoW-1:0] VcoMinHz  = 35'd240000000;
  localparam logic [VcoW-1:0] VcoMaxHz  = 35'd480000000;
  localparam logic [3:0]      NMin      = 4'd2;
  localparam logic [3:0]      NMax      = 4'd15;
  localparam logic [2:0]      DivLast   = 3'd6;
  localparam logic [8:0]      MMin      = 9'd2;

endpackage

// File: design/pll_divider_search.sv
// PLL divider search top level: bit-serial divisions and multiply driven by a sequencer.
// Depends on pds_pkg.
//
//  channel | ports                         | direction
//  in      | in_valid, in_stall, in_target_khz | target clock in
//  out     | out_valid, out_stall, out_pll_word, out_found | packed PLL word out
//  cfg     | cfg_valid, cfg_ready, cfg_data | reference frequency write
//
// Each candidate (post divider, N) runs a restoring division by 2*fref, a
// shift-add multiply and a division by N.
// A full search covers up to 98 candidates; one item at a time.
// Reset (synchronous) returns to idle with fref = 14318180 Hz.
// in_stall is high while a search runs; a finished result waits in the output
// register until out_stall drops.
`timescale 1ns / 1ps
module pll_divider_search
  import pds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TgtW-1:0]   in_target_khz,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [17:0]       out_pll_word,
  output logic              out_found,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [RefW-1:0]   cfg_data
);

  pds_state_t state_r, state_nxt;

  logic [RefW-1:0] fref_r;
  logic [TgtW-1:0] tkhz_r;
  logic [HzW-1:0]  thz_r;
  logic [2:0]      d_r;
  logic [3:0]      n_r;
  logic [5:0]      cnt_r;
  logic [NumW-1:0] x_r;
  logic [RefW:0]   rem_r;
  logic [8:0]      q_r;
  logic            ovf_r;
  logic [7:0]      m_r;
  logic [7:0]      msh_r;
  logic [VcoW-1:0] p_r;
  logic [VcoW-1:0] v_r;
  logic [3:0]      r_r;
  logic [ErrW-1:0] best_err_r;
  logic [7:0]      best_m_r;
  logic [3:0]      best_n_r;
  logic [2:0]      best_d_r;
  logic            have_r;
  logic            out_valid_r;
  logic [17:0]     out_word_r;
  logic            out_found_r;

  // combinational datapath
  logic [RefW:0]   dsor;
  logic [RefW+1:0] mtrial;
  logic            mbit;
  logic [4:0]      atrial;
  logic            abit;
  logic [32:0]     tn;
  logic [NumW-1:0] num;
  logic            m_ok;
  logic [VcoW-1:0] vlo, vhi;
  logic            vco_ok;
  logic [VcoW-1:0] actual, err;
  logic            err_better, err_good;
  logic            out_free;
  logic [1:0]      od, pod;

  assign dsor   = {fref_r, 1'b0};
  assign mtrial = {rem_r, x_r[NumW-1]};
  assign mbit   = mtrial >= {1'b0, dsor};
  assign atrial = {r_r, v_r[VcoW-1]};
  assign abit   = atrial >= {1'b0, n_r};
  assign tn     = 33'(thz_r) * 33'(n_r);
  assign num    = (NumW'(tn) << (d_r + 3'd1)) + NumW'(fref_r);
  assign m_ok   = !ovf_r && !q_r[8] && (q_r >= MMin);
  assign vlo    = VcoMinHz * VcoW'(n_r);
  assign vhi    = VcoMaxHz * VcoW'(n_r);
  assign vco_ok = (p_r >= vlo) && (p_r <= vhi);
  assign actual = v_r >> d_r;
  assign err    = (actual > VcoW'(thz_r)) ? actual - VcoW'(thz_r) : VcoW'(thz_r) - actual;
  assign err_better = err < VcoW'(best_err_r);
  assign err_good   = err < GoodErr;
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    if (best_d_r <= 3'd3) begin
      od  = best_d_r[1:0];
      pod = 2'd0;
    end else begin
      od  = 2'd3;
      pod = 2'(best_d_r - 3'd3);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PREP;
      ST_PREP: state_nxt = (fref_r == '0) ? ST_FIN : ST_LOAD;
      ST_LOAD: state_nxt = ST_MDIV;
      ST_MDIV: if (cnt_r == '0) state_nxt = ST_MCHK;
      ST_MCHK: state_nxt = m_ok ? ST_MUL : ST_NEXT;
      ST_MUL:  if (cnt_r == '0) state_nxt = ST_VCHK;
      ST_VCHK: state_nxt = vco_ok ? ST_ADIV : ST_NEXT;
      ST_ADIV: if (cnt_r == '0) state_nxt = ST_ERR;
      ST_ERR:  state_nxt = err_good ? ST_FIN : ST_NEXT;
      ST_NEXT: state_nxt = (n_r == NMax && d_r == DivLast) ? ST_FIN : ST_LOAD;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    cfg_ready = (state_r == ST_IDLE);
  end

  assign out_valid    = out_valid_r;
  assign out_pll_word = out_word_r;
  assign out_found    = out_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fref_r      <= RefReset;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) fref_r <= cfg_data;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_valid) tkhz_r <= in_target_khz;
      ST_PREP: begin
        thz_r      <= (HzW'(tkhz_r) << 10) - (HzW'(tkhz_r) << 4) - (HzW'(tkhz_r) << 3);
        best_err_r <= StartErr;
        have_r     <= 1'b0;
        d_r        <= '0;
        n_r        <= NMin;
      end
      ST_LOAD: begin
        x_r   <= num;
        rem_r <= '0;
        q_r   <= '0;
        ovf_r <= 1'b0;
        cnt_r <= 6'(NumW - 1);
      end
      ST_MDIV: begin
        // shift one dividend bit in; keep a sticky flag once M passes 255
        rem_r <= mbit ? (RefW+1)'(mtrial - {1'b0, dsor}) : mtrial[RefW:0];
        x_r   <= {x_r[NumW-2:0], 1'b0};
        ovf_r <= ovf_r | q_r[8];
        q_r   <= {q_r[7:0], mbit};
        cnt_r <= cnt_r - 6'd1;
      end
      ST_MCHK: begin
        m_r   <= q_r[7:0];
        msh_r <= q_r[7:0];
        p_r   <= '0;
        cnt_r <= 6'd7;
      end
      ST_MUL: begin
        p_r   <= (p_r << 1) + (msh_r[7] ? VcoW'(fref_r) : '0);
        msh_r <= {msh_r[6:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
      end
      ST_VCHK: begin
        v_r   <= p_r;
        r_r   <= '0;
        cnt_r <= 6'(VcoW - 1);
      end
      ST_ADIV: begin
        // quotient bits fill v_r from the bottom as dividend bits leave the top
        r_r   <= abit ? 4'(atrial - {1'b0, n_r}) : atrial[3:0];
        v_r   <= {v_r[VcoW-2:0], abit};
        cnt_r <= cnt_r - 6'd1;
      end
      ST_ERR: if (err_better) begin
        best_err_r <= ErrW'(err);
        best_m_r   <= m_r;
        best_n_r   <= n_r;
        best_d_r   <= d_r;
        have_r     <= 1'b1;
      end
      ST_NEXT: begin
        if (n_r == NMax) begin
          n_r <= NMin;
          d_r <= d_r + 3'd1;
        end else begin
          n_r <= n_r + 4'd1;
        end
      end
      ST_FIN: if (out_free) begin
        out_found_r <= have_r;
        out_word_r  <= have_r ? {1'b1, 1'b0, pod, od, best_n_r, best_m_r} : '0;
      end
      default: ;
    endcase
  end

  a_found_pwr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> out_word_r[17])
    else $error("found result without power-on bit");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_word_r == '0)
    else $error("failed search with non-zero word");

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_PREP)
    else $error("accepted transaction did not start search");

  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MDIV |-> n_r >= NMin && d_r <= DivLast)
    else $error("candidate index out of range");

endmodule

// File: bench/tb_pll_divider_search.sv
// Self-checking bench for pll_divider_search: drives target clocks, predicts the PLL word.
// Depends on pds_pkg and the pll_divider_search RTL.
`timescale 1ns / 1ps
module tb_pll_divider_search
  import pds_pkg::*;
();

  localparam int unsigned WatchLimit = 200000;
  localparam int unsigned DrainCycles = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TgtW-1:0] in_target_khz = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [17:0] out_pll_word;
  logic out_found;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RefW-1:0] cfg_data = '0;

  typedef struct packed {
    logic [17:0] word;
    logic        found;
  } pll_result_t;

  logic [TgtW-1:0] target_queue[$];
  pll_result_t     expected_words[$];
  logic [RefW-1:0] fref_model = RefReset;
  int unsigned     mismatches = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     gap_left = 0;
  int unsigned     stall_left = 0;
  bit              long_hold = 1'b0;
  bit              sender_paused = 1'b0;
  bit              stim_done = 1'b0;
  int unsigned     directed[11] = '{0, 1, 25175, 65000, 108000, 240000, 300000, 480000,
                                    524287, 7500, 3750};

  pll_divider_search dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_target_khz, .out_valid, .out_stall,
    .out_pll_word, .out_found, .cfg_valid, .cfg_ready, .cfg_data
  );

  always #1 clk = ~clk;

  function automatic pll_result_t search_dividers(logic [TgtW-1:0] tkhz,
                                                  logic [RefW-1:0] fref);
    pll_result_t res;
    longint unsigned tgt, num, m, vco, act, err, best_err;
    int unsigned best_m, best_n, best_d, od, pod;
    bit have, done;
    tgt = longint'(tkhz) * 1000;
    best_err = 1000000000;
    best_m = 0; best_n = 0; best_d = 0;
    have = 0; done = 0;
    if (fref != 0) begin
      for (int d = 0; d < 7 && !done; d++) begin
        for (int n = 2; n <= 15; n++) begin
          num = tgt * (64'd1 << d) * n;
          m = (2 * num + fref) / (2 * longint'(fref));
          if (m < 2 || m > 255) continue;
          vco = longint'(fref) * m;
          if (vco < 64'd240000000 * n || vco > 64'd480000000 * n) continue;
          act = vco / (n * (64'd1 << d));
          err = (act > tgt) ? act - tgt : tgt - act;
          if (err < best_err) begin
            best_err = err; best_m = 32'(m); best_n = n; best_d = d; have = 1;
          end
          if (err < 1000) begin
            done = 1;
            break;
          end
        end
      end
    end
    res = '0;
    if (have) begin
      od = (best_d <= 3) ? best_d : 3;
      pod = (best_d <= 3) ? 0 : best_d - 3;
      res.word = 18'(1 << 17) | 18'(pod << 14) | 18'(od << 12) | 18'(best_n << 8)
               | 18'(best_m);
      res.found = 1'b1;
    end
    return res;
  endfunction

  function automatic int unsigned random_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // driver: one transaction from the queue, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      expected_words.push_back(search_dividers(in_target_khz, fref_model));
      gap_left <= random_gap();
      if (gap_left == 0 && target_queue.size() > 0 && !sender_paused) begin
        in_target_khz <= target_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (target_queue.size() > 0 && !sender_paused) begin
        in_target_khz <= target_queue.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // monitor: check each result transaction, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_pll_word), 32'd0);
        end else begin
          if (out_pll_word !== expected_words[0].word)
            report_mismatch("pll_word", 32'(out_pll_word), 32'(expected_words[0].word));
          if (out_found !== expected_words[0].found)
            report_mismatch("found", 32'(out_found), 32'(expected_words[0].found));
          void'(expected_words.pop_front());
        end
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left <= random_gap();
      end
    end
  end

  // watchdog: count cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (target_queue.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_fref(logic [RefW-1:0] value);
    wait_drained();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fref_model = value;
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: target_queue.push_back(TgtW'($urandom));
        1: target_queue.push_back(TgtW'($urandom_range(0, 10000)));
        default: target_queue.push_back(TgtW'($urandom_range(10000, 300000)));
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // directed: field extremes, near-exact and unreachable targets at reset fref
    foreach (directed[i])
      target_queue.push_back(TgtW'(directed[i]));
    wait_drained();
    write_fref(27'd0);
    target_queue.push_back(19'd25175);
    target_queue.push_back(19'd524287);
    write_fref(27'd1000000);
    target_queue.push_back(19'd25000);
    target_queue.push_back(19'd100000);
    write_fref(27'd100000000);
    target_queue.push_back(19'd25000);
    target_queue.push_back(19'd150000);
    write_fref(27'h7FFFFFF);
    target_queue.push_back(19'd74250);
    target_queue.push_back(19'h2AAAA);
    target_queue.push_back(19'h55555);
    // receiver holds off long while the sender keeps offering
    write_fref(27'd14318180);
    fork
      begin
        long_hold <= 1'b1;
        repeat (30000) @(posedge clk);
        long_hold <= 1'b0;
      end
    join_none
    queue_random(8);
    // sender pause until every result is back
    wait_drained();
    queue_random(30);
    write_fref(27'd27000000);
    queue_random(20);
    write_fref(27'($urandom_range(1000000, 100000000)));
    queue_random(20);
    wait_drained();
    stim_done = 1'b1;
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
